// ----- hw/rtl/pwa_pkg.sv -----
// ----------------------------------------------------------------------------
// PID regulator shared definitions
// Types, widths, micro-op codes and the control store of the sequencer.
// ----------------------------------------------------------------------------
package pwa_pkg;

   localparam int GAIN_W   = 16;
   localparam int LIM_W    = 24;
   localparam int OUT_W    = 32;
   localparam int OPB_W    = 33;
   localparam int PROD_W   = GAIN_W + OPB_W;
   localparam int ACC_W    = PROD_W + 2;
   localparam int SAT_IN_W = ACC_W;
   localparam int STEP_W   = 4;
   localparam int CSR_IDX_W = 3;

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type ST_LOAD   = 4'd0;
   localparam step_type ST_FILT   = 4'd1;
   localparam step_type ST_DEST   = 4'd2;
   localparam step_type ST_MEM    = 4'd3;
   localparam step_type ST_ACC_I  = 4'd4;
   localparam step_type ST_ACC_D  = 4'd5;
   localparam step_type ST_BYP    = 4'd6;
   localparam step_type ST_BCLAMP = 4'd7;
   localparam step_type ST_BKI    = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SETPOINT  = 3'd0,
      REG_PROP_GAIN = 3'd1,
      REG_INTEG_GAIN = 3'd2,
      REG_DERIV_GAIN = 3'd3,
      REG_FILTER_COEF = 3'd4,
      REG_INTEG_UPPER = 3'd5,
      REG_INTEG_LOWER = 3'd6,
      REG_DERIV_SOURCE = 3'd7
   } csr_reg_type;

   typedef enum logic [2:0] {
      MUL_NONE    = 3'd0,
      MUL_FC_DIFF = 3'd1,
      MUL_KP_ERR  = 3'd2,
      MUL_KI_INT  = 3'd3,
      MUL_KD_DER  = 3'd4
   } mul_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_type;

   typedef enum logic [1:0] {
      DER_HOLD = 2'd0,
      DER_EST  = 2'd1,
      DER_AUX  = 2'd2
   } der_type;

   typedef enum logic [1:0] {
      BR_NEXT   = 2'd0,
      BR_IF_BYP = 2'd1,
      BR_GOTO   = 2'd2,
      BR_END    = 2'd3
   } br_type;

   typedef struct packed {
      mul_type  mul;
      acc_type  acc;
      logic     ld_err;
      logic     ld_sum;
      logic     ld_clamp;
      der_type  der;
      logic     ld_mem;
      br_type   br;
      step_type target;
   } uword_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] ki;
      logic signed [GAIN_W-1:0] kd;
      logic signed [GAIN_W-1:0] fc;
      logic signed [LIM_W-1:0]  upper;
      logic signed [LIM_W-1:0]  lower;
      logic                     bypass;
   } cfg_type;

   typedef struct packed {
      logic                    clip;
      logic signed [OUT_W-1:0] val;
   } sat_type;

   localparam uword_type UW_NOP = '{
      mul: MUL_NONE, acc: ACC_HOLD, ld_err: 1'b0, ld_sum: 1'b0, ld_clamp: 1'b0,
      der: DER_HOLD, ld_mem: 1'b0, br: BR_NEXT, target: ST_LOAD
   };

   function automatic sat_type sat32(input logic signed [SAT_IN_W-1:0] v);
      logic signed [SAT_IN_W-1:0] hi;
      logic signed [SAT_IN_W-1:0] lo;
      sat_type r;
      hi = SAT_IN_W'(32'sh7fffffff);
      lo = SAT_IN_W'(32'sh80000000);
      if (v > hi) begin
         r.clip = 1'b1;
         r.val  = 32'sh7fffffff;
      end else if (v < lo) begin
         r.clip = 1'b1;
         r.val  = 32'sh80000000;
      end else begin
         r.clip = 1'b0;
         r.val  = v[OUT_W-1:0];
      end
      return r;
   endfunction

   function automatic uword_type ucode(input step_type s);
      uword_type w;
      w = UW_NOP;
      unique case (s)
         ST_LOAD: begin
            w.ld_err = 1'b1;
            w.br     = BR_IF_BYP;
            w.target = ST_BYP;
         end
         ST_FILT: begin
            w.mul    = MUL_FC_DIFF;
            w.ld_sum = 1'b1;
         end
         ST_DEST: begin
            w.der      = DER_EST;
            w.ld_clamp = 1'b1;
            w.mul      = MUL_KP_ERR;
         end
         ST_MEM: begin
            w.ld_mem = 1'b1;
            w.acc    = ACC_LOAD;
            w.mul    = MUL_KI_INT;
         end
         ST_ACC_I: begin
            w.acc = ACC_ADD;
            w.mul = MUL_KD_DER;
         end
         ST_ACC_D: begin
            w.acc = ACC_ADD;
            w.br  = BR_END;
         end
         ST_BYP: begin
            w.ld_sum = 1'b1;
            w.der    = DER_AUX;
            w.mul    = MUL_KP_ERR;
         end
         ST_BCLAMP: begin
            w.ld_clamp = 1'b1;
            w.acc      = ACC_LOAD;
         end
         ST_BKI: begin
            w.mul    = MUL_KI_INT;
            w.br     = BR_GOTO;
            w.target = ST_ACC_I;
         end
         default: begin
            w = UW_NOP;
         end
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/pwa_csr.sv -----
// ----------------------------------------------------------------------------
// PID regulator configuration registers
// Holds setpoint, gains, filter coefficient, integrator limits and mode.
// ----------------------------------------------------------------------------
module pwa_csr #(
   parameter int DATA_WIDTH = 16,
   localparam int CSR_DW = (DATA_WIDTH > 24) ? DATA_WIDTH : 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pwa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DW-1:0]                   csr_data,
   output logic signed [DATA_WIDTH-1:0]        setpoint,
   output pwa_pkg::cfg_type                    cfg
);
   import pwa_pkg::*;

   logic signed [DATA_WIDTH-1:0] setpoint_ff, setpoint_in;
   cfg_type                      cfg_ff, cfg_in;
   logic signed [LIM_W-1:0]      lim_val;

   assign csr_ready = 1'b1;
   assign lim_val   = csr_data[LIM_W-1:0];

   always_comb begin
      setpoint_in = setpoint_ff;
      cfg_in      = cfg_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_SETPOINT:    setpoint_in = csr_data[DATA_WIDTH-1:0];
            REG_PROP_GAIN:   cfg_in.kp = csr_data[GAIN_W-1:0];
            REG_INTEG_GAIN:  cfg_in.ki = csr_data[GAIN_W-1:0];
            REG_DERIV_GAIN:  cfg_in.kd = csr_data[GAIN_W-1:0];
            REG_FILTER_COEF: cfg_in.fc = csr_data[GAIN_W-1:0];
            REG_INTEG_UPPER: begin
               if (lim_val < cfg_ff.lower) begin
                  cfg_in.upper = cfg_ff.lower;
                  cfg_in.lower = lim_val;
               end else begin
                  cfg_in.upper = lim_val;
               end
            end
            REG_INTEG_LOWER: begin
               if (lim_val > cfg_ff.upper) begin
                  cfg_in.lower = cfg_ff.upper;
                  cfg_in.upper = lim_val;
               end else begin
                  cfg_in.lower = lim_val;
               end
            end
            REG_DERIV_SOURCE: cfg_in.bypass = csr_data[0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         cfg_ff      <= '0;
      end else begin
         setpoint_ff <= setpoint_in;
         cfg_ff      <= cfg_in;
      end
   end

   assign setpoint = setpoint_ff;
   assign cfg      = cfg_ff;

endmodule

// ----- hw/rtl/pwa_useq.sv -----
// ----------------------------------------------------------------------------
// PID regulator microcode sequencer
// Step counter over the control store, with branch on mode and output stall.
// ----------------------------------------------------------------------------
module pwa_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                bypass,
   input  logic                out_free,
   output logic                busy,
   output pwa_pkg::uword_type  ctl
);
   import pwa_pkg::*;

   step_type  step_ff, step_in;
   logic      running_ff, running_in;
   uword_type uw;
   logic      go;

   assign uw   = ucode(step_ff);
   assign go   = running_ff && !(uw.br == BR_END && !out_free);
   assign ctl  = go ? uw : UW_NOP;
   assign busy = running_ff;

   always_comb begin
      step_in    = step_ff;
      running_in = running_ff;
      if (start) begin
         step_in    = ST_LOAD;
         running_in = 1'b1;
      end else if (go) begin
         case (uw.br)
            BR_NEXT:   step_in = step_ff + step_type'(1);
            BR_IF_BYP: step_in = bypass ? uw.target : step_ff + step_type'(1);
            BR_GOTO:   step_in = uw.target;
            BR_END: begin
               step_in    = ST_LOAD;
               running_in = 1'b0;
            end
            default:   step_in = ST_LOAD;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= ST_LOAD;
         running_ff <= 1'b0;
      end else begin
         step_ff    <= step_in;
         running_ff <= running_in;
      end
   end

endmodule

// ----- hw/rtl/pwa_dpath.sv -----
// ----------------------------------------------------------------------------
// PID regulator datapath
// Error and integrator adders, clamp, one shared multiplier, accumulator,
// derivative estimator state and the result register.
// ----------------------------------------------------------------------------
module pwa_dpath #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  logic signed [DATA_WIDTH-1:0]         meas_in,
   input  logic signed [DATA_WIDTH-1:0]         aux_in,
   input  logic                                 clr_in,
   input  logic signed [DATA_WIDTH-1:0]         setpoint,
   input  pwa_pkg::cfg_type                     cfg,
   input  pwa_pkg::uword_type                   ctl,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [pwa_pkg::OUT_W-1:0]     drive,
   output logic                                 saturated,
   output logic                                 out_free
);
   import pwa_pkg::*;

   localparam int ERR_W = DATA_WIDTH + 1;
   localparam int SUM_W = ((ERR_W > LIM_W) ? ERR_W : LIM_W) + 1;
   localparam int RND_W = PROD_W + 1;
   localparam logic signed [RND_W-1:0] RND = (RND_W'(1) << FRAC_BITS) >> 1;

   logic signed [DATA_WIDTH-1:0] meas_ff, meas_in_r, aux_ff, aux_in_r;
   logic                         clr_ff, clr_in_r;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic signed [OPB_W-1:0]      diff_ff, diff_in;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic signed [LIM_W-1:0]      integral_ff, integral_in;
   logic signed [OUT_W-1:0]      dmem_ff, dmem_in;
   logic signed [OUT_W-1:0]      deriv_ff, deriv_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [OUT_W-1:0]      drive_ff, drive_in;
   logic                         sat_ff, sat_in;
   logic                         valid_ff, valid_in;

   logic signed [GAIN_W-1:0]     mul_a;
   logic signed [OPB_W-1:0]      mul_b;
   logic signed [LIM_W-1:0]      clamp_val;
   logic signed [RND_W-1:0]      rnd, shr;
   logic signed [ACC_W-1:0]      acc_sum;
   sat_type                      est_sat, mem_sat, drive_sat;
   logic                         emit;

   assign emit     = (ctl.br == BR_END);
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      case (ctl.mul)
         MUL_FC_DIFF: begin
            mul_a = cfg.fc;
            mul_b = diff_ff;
         end
         MUL_KP_ERR: begin
            mul_a = cfg.kp;
            mul_b = OPB_W'(err_ff);
         end
         MUL_KI_INT: begin
            mul_a = cfg.ki;
            mul_b = OPB_W'(integral_ff);
         end
         MUL_KD_DER: begin
            mul_a = cfg.kd;
            mul_b = OPB_W'(deriv_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      if (sum_ff > SUM_W'(cfg.upper)) begin
         clamp_val = cfg.upper;
      end else if (sum_ff < SUM_W'(cfg.lower)) begin
         clamp_val = cfg.lower;
      end else begin
         clamp_val = sum_ff[LIM_W-1:0];
      end
   end

   assign rnd       = RND_W'(prod_ff) + RND;
   assign shr       = rnd >>> FRAC_BITS;
   assign est_sat   = sat32(SAT_IN_W'(shr));
   assign mem_sat   = sat32(SAT_IN_W'(deriv_ff) + SAT_IN_W'(aux_ff));
   assign acc_sum   = acc_ff + ACC_W'(prod_ff);
   assign drive_sat = sat32(acc_sum);

   always_comb begin
      meas_in_r   = meas_ff;
      aux_in_r    = aux_ff;
      clr_in_r    = clr_ff;
      err_in      = err_ff;
      diff_in     = diff_ff;
      sum_in      = sum_ff;
      integral_in = integral_ff;
      dmem_in     = dmem_ff;
      deriv_in    = deriv_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      drive_in    = drive_ff;
      sat_in      = sat_ff;
      valid_in    = valid_ff;

      if (load) begin
         meas_in_r = meas_in;
         aux_in_r  = aux_in;
         clr_in_r  = clr_in;
      end
      if (ctl.ld_err) begin
         err_in  = ERR_W'(setpoint) - ERR_W'(meas_ff);
         diff_in = OPB_W'(dmem_ff) - OPB_W'(aux_ff);
         if (clr_ff) begin
            integral_in = '0;
         end
      end
      if (ctl.ld_sum) begin
         sum_in = SUM_W'(integral_ff) + SUM_W'(err_ff);
      end
      if (ctl.ld_clamp) begin
         integral_in = clamp_val;
      end
      case (ctl.der)
         DER_EST: deriv_in = est_sat.val;
         DER_AUX: deriv_in = OUT_W'(aux_ff);
         default: deriv_in = deriv_ff;
      endcase
      if (ctl.ld_mem) begin
         dmem_in = mem_sat.val;
      end
      if (ctl.mul != MUL_NONE) begin
         prod_in = mul_a * mul_b;
      end
      case (ctl.acc)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_ADD:  acc_in = acc_sum;
         default:  acc_in = acc_ff;
      endcase
      if (emit) begin
         drive_in = drive_sat.val;
         sat_in   = drive_sat.clip;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      meas_ff  <= meas_in_r;
      aux_ff   <= aux_in_r;
      clr_ff   <= clr_in_r;
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      sum_ff   <= sum_in;
      deriv_ff <= deriv_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         dmem_ff     <= '0;
         valid_ff    <= 1'b0;
      end else begin
         integral_ff <= integral_in;
         dmem_ff     <= dmem_in;
         valid_ff    <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign drive     = drive_ff;
   assign saturated = sat_ff;

endmodule

// ----- hw/rtl/pid_with_antiwindup_top.sv -----
// ----------------------------------------------------------------------------
// PID regulator with clamped integrator
// The input is taken only while the sequencer is idle, so a new item is not
// accepted until the six-step microprogram that runs every product through
// the single shared multiplier has finished with the last one.
// A finished result waits in the output register while the next item starts.
// Synchronous reset clears the integrator, the derivative state and all
// configuration registers to zero.
// ----------------------------------------------------------------------------
module pid_with_antiwindup_top #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8,
   localparam int REQ_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
   localparam int CSR_DW = (DATA_WIDTH > 24) ? DATA_WIDTH : 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [REQ_W-1:0]                   req_tdata,   // measurement, aux_value
   input  logic [0:0]                         req_tuser,   // clear_integral
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pwa_pkg::OUT_W-1:0]          rsp_tdata,   // drive
   output logic [0:0]                         rsp_tuser,   // saturated
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pwa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DW-1:0]                  csr_data
);
   import pwa_pkg::*;

   logic signed [DATA_WIDTH-1:0] setpoint;
   cfg_type                      cfg;
   uword_type                    ctl;
   logic                         busy;
   logic                         accept;
   logic                         out_free;
   logic signed [OUT_W-1:0]      drive;
   logic                         saturated;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   pwa_csr #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .setpoint  (setpoint),
      .cfg       (cfg)
   );

   pwa_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .bypass   (cfg.bypass),
      .out_free (out_free),
      .busy     (busy),
      .ctl      (ctl)
   );

   pwa_dpath #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .meas_in   (req_tdata[DATA_WIDTH-1:0]),
      .aux_in    (req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
      .clr_in    (req_tuser[0]),
      .setpoint  (setpoint),
      .cfg       (cfg),
      .ctl       (ctl),
      .rsp_ready (rsp_tready),
      .rsp_valid (rsp_tvalid),
      .drive     (drive),
      .saturated (saturated),
      .out_free  (out_free)
   );

   assign rsp_tdata    = drive;
   assign rsp_tuser[0] = saturated;

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// PID regulator with clamped integrator: self-checking bench
// Streams measurement samples through the regulator under a series of gain,
// limit and derivative-source settings. A bit-true model predicts the drive
// and saturation flag of every accepted beat, and each result beat is checked
// field by field against the oldest prediction. The sender runs in bursts
// with random gaps, and the receiver stalls on its own patterns, including
// long holds that back the block up.
// ----------------------------------------------------------------------------
module testbench;
   import pwa_pkg::*;

   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 8;
   localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam longint MAX32 = 64'sd2147483647;
   localparam longint MIN32 = -64'sd2147483648;

   typedef struct {
      logic signed [15:0] meas;
      logic signed [15:0] aux;
      logic               clr;
   } sensor_sample_type;

   typedef struct packed {
      logic signed [31:0] drive;
      logic               saturated;
   } control_out_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [0:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   // Register mirror and regulator state of the prediction.
   logic signed [15:0] sp_reg = '0;
   logic signed [15:0] kp_reg = '0;
   logic signed [15:0] ki_reg = '0;
   logic signed [15:0] kd_reg = '0;
   logic signed [15:0] fc_reg = '0;
   logic signed [23:0] hi_lim = '0;
   logic signed [23:0] lo_lim = '0;
   logic               bypass_reg = 1'b0;
   logic signed [23:0] integ_state = '0;
   logic signed [31:0] deriv_mem = '0;

   sensor_sample_type sample_queue[$];
   control_out_type   drive_expected[$];
   int  items_queued = 0;
   int  results_seen = 0;
   int  errors = 0;
   int  phase_index = 0;
   logic req_taken = 1'b0;

   int burst_left = 0;
   int gap_left = 0;
   int hold_left = 0;
   int held_phase = -1;
   int mode_left = 0;
   int stall_mode = 0;
   logic [15:0] stall_pat = '0;

   pid_with_antiwindup_top #(
      .DATA_WIDTH(DATA_W),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip32(longint v, output logic hit);
      hit = 1'b0;
      if (v > MAX32) begin
         hit = 1'b1;
         return MAX32;
      end
      if (v < MIN32) begin
         hit = 1'b1;
         return MIN32;
      end
      return v;
   endfunction

   function automatic control_out_type control_step(logic signed [15:0] meas,
                                                    logic signed [15:0] aux, logic clr);
      longint err;
      longint acc;
      longint deriv;
      longint prod;
      longint total;
      logic hit;
      logic drop;
      control_out_type r;
      if (clr) integ_state = '0;
      err = longint'(sp_reg) - longint'(meas);
      acc = longint'(integ_state) + err;
      if (acc > longint'(hi_lim)) acc = longint'(hi_lim);
      else if (acc < longint'(lo_lim)) acc = longint'(lo_lim);
      integ_state = acc[23:0];
      if (bypass_reg) begin
         deriv = longint'(aux);
      end else begin
         prod = longint'(fc_reg) * (longint'(deriv_mem) - longint'(aux)) + ROUND_HALF;
         deriv = clip32(prod >>> FRAC_BITS, drop);
         deriv_mem = 32'(clip32(deriv + longint'(aux), drop));
      end
      total = longint'(kp_reg) * err + longint'(ki_reg) * longint'(integ_state)
            + longint'(kd_reg) * deriv;
      r.drive = 32'(clip32(total, hit));
      r.saturated = hit;
      return r;
   endfunction

   function automatic void mirror_csr(csr_reg_type idx, logic [23:0] val);
      logic signed [23:0] lim;
      lim = val;
      case (idx)
         REG_SETPOINT:     sp_reg = val[15:0];
         REG_PROP_GAIN:    kp_reg = val[15:0];
         REG_INTEG_GAIN:   ki_reg = val[15:0];
         REG_DERIV_GAIN:   kd_reg = val[15:0];
         REG_FILTER_COEF:  fc_reg = val[15:0];
         REG_INTEG_UPPER: begin
            if (lim < lo_lim) begin
               hi_lim = lo_lim;
               lo_lim = lim;
            end else begin
               hi_lim = lim;
            end
         end
         REG_INTEG_LOWER: begin
            if (lim > hi_lim) begin
               lo_lim = hi_lim;
               hi_lim = lim;
            end else begin
               lo_lim = lim;
            end
         end
         REG_DERIV_SOURCE: bypass_reg = val[0];
         default: begin
         end
      endcase
   endfunction

   function automatic logic [15:0] pick_value(logic [15:0] centre);
      logic [15:0] off;
      off = 16'($urandom_range(0, 64));
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2, 3: return centre + off - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         7: return 16'($urandom);
         default: return 16'($urandom_range(0, 1023)) - 16'd512;
      endcase
   endfunction

   function automatic logic [23:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2, 3: return 24'($urandom_range(0, 8191)) - 24'd4096;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic write_csr(csr_reg_type idx, logic [23:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      mirror_csr(idx, val);
   endtask

   task automatic end_csr();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure_fixed(logic [15:0] sp, logic [15:0] gain, logic [15:0] fc,
                                  logic [23:0] lower, logic [23:0] upper, logic src);
      write_csr(REG_SETPOINT, {8'h00, sp});
      write_csr(REG_PROP_GAIN, {8'h00, gain});
      write_csr(REG_INTEG_GAIN, {8'h00, gain});
      write_csr(REG_DERIV_GAIN, {8'h00, gain});
      write_csr(REG_FILTER_COEF, {8'h00, fc});
      write_csr(REG_INTEG_LOWER, lower);
      write_csr(REG_INTEG_UPPER, upper);
      write_csr(REG_DERIV_SOURCE, {23'h0, src});
      end_csr();
   endtask

   task automatic configure_random();
      write_csr(REG_SETPOINT, {8'($urandom), pick_value(16'h0000)});
      write_csr(REG_PROP_GAIN, {8'($urandom), pick_gain()});
      write_csr(REG_INTEG_GAIN, {8'($urandom), pick_gain()});
      write_csr(REG_DERIV_GAIN, {8'($urandom), pick_gain()});
      write_csr(REG_FILTER_COEF, {8'($urandom), pick_gain()});
      if ($urandom_range(0, 1)) begin
         write_csr(REG_INTEG_UPPER, pick_limit());
         write_csr(REG_INTEG_LOWER, pick_limit());
      end else begin
         write_csr(REG_INTEG_LOWER, pick_limit());
         write_csr(REG_INTEG_UPPER, pick_limit());
      end
      write_csr(REG_DERIV_SOURCE, {23'($urandom), 1'($urandom)});
      end_csr();
   endtask

   task automatic queue_sample(logic [15:0] meas, logic [15:0] aux, logic clr);
      sensor_sample_type s;
      s.meas = meas;
      s.aux  = aux;
      s.clr  = clr;
      sample_queue.push_back(s);
      items_queued++;
   endtask

   task automatic wait_idle();
      do @(negedge clock); while (results_seen < items_queued);
      repeat (10) @(negedge clock);
   endtask

   task automatic random_phase(int count);
      logic [15:0] meas;
      logic [15:0] aux;
      configure_random();
      @(posedge clock);
      aux = 16'($urandom);
      repeat (count) begin
         meas = pick_value(sp_reg);
         aux  = pick_value(aux);
         queue_sample(meas, aux, $urandom_range(0, 15) == 0);
      end
      phase_index++;
      wait_idle();
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      sensor_sample_type nxt;
      if (!req_tvalid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sample_queue.size() != 0) begin
            nxt = sample_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {nxt.aux, nxt.meas};
            req_tuser  <= nxt.clr;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: changing stall patterns, and a long hold at the start of some phases.
   always @(negedge clock) begin
      if (phase_index != held_phase && (phase_index == 2 || phase_index == 6)) begin
         held_phase = phase_index;
         hold_left = 250;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left = $urandom_range(16, 96);
            stall_mode = $urandom_range(0, 2);
            stall_pat = 16'($urandom);
         end else begin
            mode_left--;
         end
         stall_pat = {stall_pat[14:0], stall_pat[15]};
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= stall_pat[0];
         endcase
      end
   end

   always @(posedge clock) begin
      control_out_type want;
      req_taken = 1'b0;
      if (!reset) begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            drive_expected.push_back(control_step(req_tdata[15:0], req_tdata[31:16],
                                                  req_tuser[0]));
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (drive_expected.size() == 0) begin
               errors++;
               $display("%0t: result beat with none expected, drive %0d saturated %b",
                        $time, $signed(rsp_tdata), rsp_tuser);
            end else begin
               want = drive_expected.pop_front();
               if (rsp_tdata !== want.drive) begin
                  errors++;
                  $display("%0t: drive expected %0d actual %0d", $time, want.drive,
                           $signed(rsp_tdata));
               end
               if (rsp_tuser[0] !== want.saturated) begin
                  errors++;
                  $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                           rsp_tuser[0]);
               end
            end
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Modest gains; the limits are written out of order from reset.
      configure_fixed(16'd100, 16'h0100, 16'h00c0, 24'd2000, -24'sd2000, 1'b0);
      @(posedge clock);
      queue_sample(16'd0, 16'd0, 1'b0);
      queue_sample(16'h8000, 16'h8000, 1'b0);
      queue_sample(16'h8000, 16'h7fff, 1'b0);
      queue_sample(16'h8000, 16'h7fff, 1'b0);
      queue_sample(16'h7fff, 16'h7fff, 1'b0);
      queue_sample(16'h7fff, 16'h8000, 1'b0);
      queue_sample(16'h7fff, 16'h8000, 1'b0);
      queue_sample(16'd100, 16'd100, 1'b1);
      queue_sample(16'd100, 16'hffff, 1'b0);
      wait_idle();

      configure_fixed(16'h7fff, 16'h7fff, 16'h7fff, 24'h800000, 24'h7fffff, 1'b0);
      @(posedge clock);
      queue_sample(16'h8000, 16'h8000, 1'b0);
      queue_sample(16'h7fff, 16'h7fff, 1'b1);
      queue_sample(16'h8000, 16'h7fff, 1'b0);
      queue_sample(16'h8000, 16'h8000, 1'b0);
      wait_idle();

      // The upper limit written below the lower one swaps the pair.
      configure_fixed(16'h8000, 16'h8000, 16'h8000, 24'd3000, -24'sd3000, 1'b1);
      @(posedge clock);
      queue_sample(16'h7fff, 16'h8000, 1'b0);
      queue_sample(16'h8000, 16'h7fff, 1'b0);
      queue_sample(16'd0, 16'hffff, 1'b1);
      queue_sample(16'h7fff, 16'h7fff, 1'b0);
      wait_idle();

      repeat (8) random_phase(194);

      if (errors == 0 && drive_expected.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (drive_expected.size() != 0)
            $display("%0t: %0d expected results never arrived", $time, drive_expected.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
